// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CSX_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// When the trigger holds, the consequence must hold in the next cycle.
`define CSX_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/csx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csx_pkg: shared types and constants of the CAN signal extractor
// Payload structs, command codes, queue entry layout and the length mask.
// ----------------------------------------------------------------------------
package csx_pkg;

  // Default table geometry.
  localparam int MSG_SLOTS_DEF    = 64;
  localparam int SIGS_PER_MSG_DEF = 16;

  // Most results one decode may produce.
  localparam int MAX_RES = 16;

  // Depth of the queue between front and back.
  localparam int QDEPTH = 2;

  // Command codes on the input channel.
  localparam logic [1:0] CMD_LOAD_MSG = 2'd0;
  localparam logic [1:0] CMD_LOAD_SIG = 2'd1;
  localparam logic [1:0] CMD_DECODE   = 2'd2;

  // Operations the front hands to the back.
  typedef enum logic [1:0] {
    OP_MSG,
    OP_SIG,
    OP_DEC,
    OP_NONE
  } op_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_FETCH,
    ST_EMIT,
    ST_RAW
  } bstate_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  slot;
    logic [3:0]  sig_index;
    logic [28:0] can_id;
    logic [4:0]  sig_count;
    logic [5:0]  start_pos;
    logic [6:0]  sig_length;
    logic [3:0]  dlc;
    logic [63:0] data;
  } in_item_t;

  typedef struct packed {
    logic [28:0] frame_id;
    logic [5:0]  sig_start;
    logic [6:0]  sig_bits;
    logic [63:0] value;
    logic        known;
    logic        last;
  } out_item_t;

  // Classified work item held in the queue.
  typedef struct packed {
    op_t         op;
    logic [5:0]  slot;
    logic [3:0]  sig_index;
    logic [28:0] can_id;
    logic [4:0]  count;
    logic [5:0]  start;
    logic [6:0]  len;
    logic [3:0]  nb;
    logic [63:0] payload;
    logic [63:0] data;
  } qitem_t;

  // One message table word.
  typedef struct packed {
    logic        valid;
    logic [28:0] can_id;
    logic [4:0]  count;
  } slot_word_t;

  // One signal descriptor word.
  typedef struct packed {
    logic [5:0] start;
    logic [6:0] len;
  } entry_t;

  // Mask of the low len bits, all ones from 64 up.
  function automatic logic [63:0] len_mask(input logic [6:0] len);
    logic [63:0] m;
    if (len >= 7'd64) begin
      m = '1;
    end else begin
      m = (64'd1 << len) - 64'd1;
    end
    return m;
  endfunction

endpackage

// ===== rtl/csx_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csx_queue: small FIFO between front and back
// Holds classified work items so that each side can stall on its own.
// ----------------------------------------------------------------------------
module csx_queue
  import csx_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_valid,
  output logic   wr_ready,
  input  qitem_t wr_item,
  output logic   rd_valid,
  input  logic   rd_ready,
  output qitem_t rd_item
);

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  qitem_t           mem [QDEPTH];
  logic [QAW-1:0]   wptr;
  logic [QAW-1:0]   rptr;
  logic [QCW-1:0]   cnt;
  logic             do_wr;
  logic             do_rd;

  // Status and transfer qualifiers.
  assign wr_ready = (cnt != QCW'(QDEPTH));
  assign rd_valid = (cnt != '0);
  assign rd_item  = mem[rptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == QAW'(QDEPTH - 1)) ? '0 : wptr + QAW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == QAW'(QDEPTH - 1)) ? '0 : rptr + QAW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + QCW'(1);
      end else if (!do_wr && do_rd) begin
        cnt <= cnt - QCW'(1);
      end
    end
  end

endmodule

// ===== rtl/csx_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csx_front: input acceptance and command classification
// Checks load ranges, saturates counts, packs the frame payload and pushes
// useful work into the queue. Unused commands and bad loads are dropped.
// ----------------------------------------------------------------------------
module csx_front
  import csx_pkg::*;
#(
  parameter int MSG_SLOTS    = MSG_SLOTS_DEF,
  parameter int SIGS_PER_MSG = SIGS_PER_MSG_DEF
) (
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     clearing,
  output logic     push_valid,
  input  logic     push_ready,
  output qitem_t   push_item
);

  localparam int CNT_CAP = (SIGS_PER_MSG < MAX_RES) ? SIGS_PER_MSG : MAX_RES;

  logic       slot_ok;
  logic       sig_ok;
  logic [7:0] span;
  logic [3:0] nb;
  logic [6:0] pack_shift;
  op_t        op;

  // Range checks on load commands.
  assign span    = {2'b00, in_item.start_pos} + {1'b0, in_item.sig_length};
  assign slot_ok = (32'(in_item.slot) < MSG_SLOTS);
  assign sig_ok  = slot_ok && (32'(in_item.sig_index) < SIGS_PER_MSG) &&
                   (in_item.sig_length != 7'd0) && (span <= 8'd65);

  // Byte count and right-aligned big-endian payload.
  assign nb         = (in_item.dlc > 4'd8) ? 4'd8 : in_item.dlc;
  assign pack_shift = 7'd64 - {nb, 3'b000};

  // Command decode.
  always_comb begin
    unique case (in_item.cmd)
      CMD_LOAD_MSG: op = slot_ok ? OP_MSG : OP_NONE;
      CMD_LOAD_SIG: op = sig_ok ? OP_SIG : OP_NONE;
      CMD_DECODE:   op = OP_DEC;
      default:      op = OP_NONE;
    endcase
  end

  // Work item for the back end.
  always_comb begin
    push_item           = '0;
    push_item.op        = op;
    push_item.slot      = in_item.slot;
    push_item.sig_index = in_item.sig_index;
    push_item.can_id    = in_item.can_id;
    push_item.count     = (in_item.sig_count > 5'(CNT_CAP)) ? 5'(CNT_CAP)
                                                             : in_item.sig_count;
    push_item.start     = in_item.start_pos;
    push_item.len       = in_item.sig_length;
    push_item.nb        = nb;
    push_item.payload   = in_item.data >> pack_shift;
    push_item.data      = in_item.data;
  end

  // Items are taken whenever the queue has room and the table is not clearing.
  assign in_ready   = push_ready && !clearing;
  assign push_valid = in_valid && in_ready && (op != OP_NONE);

endmodule

// ===== rtl/csx_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csx_back: table storage, slot search and result emission
// Executes queued loads and decodes in order, walks the message table for a
// match and emits one result per signal or per raw byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csx_back
  import csx_pkg::*;
#(
  parameter int MSG_SLOTS    = MSG_SLOTS_DEF,
  parameter int SIGS_PER_MSG = SIGS_PER_MSG_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_ready,
  input  qitem_t    q_item,
  output logic      clearing,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int SAW    = (MSG_SLOTS > 1) ? $clog2(MSG_SLOTS) : 1;
  localparam int SCW    = $clog2(MSG_SLOTS + 1);
  localparam int EDEPTH = MSG_SLOTS * SIGS_PER_MSG;
  localparam int EAW    = (EDEPTH > 1) ? $clog2(EDEPTH) : 1;

  // Table memories.
  slot_word_t slot_mem [MSG_SLOTS];
  entry_t     ent_mem  [EDEPTH];
  slot_word_t slot_rdata;
  entry_t     ent_rdata;

  // Sequencer registers.
  bstate_t        state, state_next;
  logic [SAW-1:0] clr_idx, clr_idx_next;
  logic [SCW-1:0] scan, scan_next;
  logic           pend, pend_next;
  logic [SAW-1:0] pend_idx, pend_idx_next;
  logic [SAW-1:0] hit_idx, hit_idx_next;
  logic [4:0]     sig_i, sig_i_next;
  logic [4:0]     sig_n, sig_n_next;
  qitem_t         cur, cur_next;
  logic           ovalid, ovalid_next;
  out_item_t      oitem, oitem_next;

  // Memory port controls.
  logic           slot_we;
  logic [SAW-1:0] slot_waddr;
  slot_word_t     slot_wdata;
  logic           slot_re;
  logic [SAW-1:0] slot_raddr;
  logic           ent_we;
  logic [EAW-1:0] ent_waddr;
  entry_t         ent_wdata;
  logic           ent_re;
  logic [EAW-1:0] ent_raddr;

  logic           pop;
  logic           oload;
  logic           out_free;
  logic           is_last;
  logic [7:0]     ent_sum;
  logic [7:0]     ent_shift;
  logic [63:0]    ent_value;

  assign out_free  = !ovalid || out_ready;
  assign q_ready   = pop;
  assign clearing  = (state == ST_CLEAR);
  assign out_valid = ovalid;
  assign out_item  = oitem;
  assign is_last   = (sig_i + 5'd1 == sig_n);

  // Signal extraction from the fetched descriptor.
  assign ent_sum   = {2'b00, ent_rdata.start} + {1'b0, ent_rdata.len};
  assign ent_shift = 8'd65 - ent_sum;
  assign ent_value = ((ent_sum <= 8'd65) && (ent_shift < 8'd64))
                   ? ((cur.payload >> ent_shift[5:0]) & len_mask(ent_rdata.len))
                   : 64'd0;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control and payload registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      pend    <= 1'b0;
      ovalid  <= 1'b0;
    end else begin
      clr_idx <= clr_idx_next;
      pend    <= pend_next;
      ovalid  <= ovalid_next;
    end
    scan     <= scan_next;
    pend_idx <= pend_idx_next;
    hit_idx  <= hit_idx_next;
    sig_i    <= sig_i_next;
    sig_n    <= sig_n_next;
    cur      <= cur_next;
    oitem    <= oitem_next;
  end

  // Message table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rdata <= slot_mem[slot_raddr];
    end
  end

  // Signal descriptor table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rdata <= ent_mem[ent_raddr];
    end
  end

  // Next state and datapath control.
  always_comb begin
    state_next    = state;
    clr_idx_next  = clr_idx;
    scan_next     = scan;
    pend_next     = 1'b0;
    pend_idx_next = pend_idx;
    hit_idx_next  = hit_idx;
    sig_i_next    = sig_i;
    sig_n_next    = sig_n;
    cur_next      = cur;
    oitem_next    = oitem;
    oload         = 1'b0;
    pop           = 1'b0;
    slot_we       = 1'b0;
    slot_waddr    = SAW'(q_item.slot);
    slot_wdata    = '0;
    slot_re       = 1'b0;
    slot_raddr    = scan[SAW-1:0];
    ent_we        = 1'b0;
    ent_waddr     = EAW'(32'(q_item.slot) * SIGS_PER_MSG + 32'(q_item.sig_index));
    ent_wdata     = '{start: q_item.start, len: q_item.len};
    ent_re        = 1'b0;
    ent_raddr     = EAW'(32'(hit_idx) * SIGS_PER_MSG + 32'(sig_i));

    unique case (state)
      // Invalidate every slot after reset.
      ST_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_idx;
        slot_wdata = '0;
        if (clr_idx == SAW'(MSG_SLOTS - 1)) begin
          state_next = ST_IDLE;
        end else begin
          clr_idx_next = clr_idx + SAW'(1);
        end
      end

      // Take the next queued item; loads finish here.
      ST_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          unique case (q_item.op)
            OP_MSG: begin
              slot_we    = 1'b1;
              slot_wdata = '{valid: 1'b1, can_id: q_item.can_id, count: q_item.count};
            end
            OP_SIG: begin
              ent_we = 1'b1;
            end
            OP_DEC: begin
              cur_next   = q_item;
              scan_next  = '0;
              state_next = ST_SEARCH;
            end
            default: begin
            end
          endcase
        end
      end

      // Read one slot a cycle, check the one read the cycle before.
      ST_SEARCH: begin
        if (scan < SCW'(MSG_SLOTS)) begin
          slot_re       = 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = scan[SAW-1:0];
          scan_next     = scan + SCW'(1);
        end
        if (pend) begin
          if (slot_rdata.valid && (slot_rdata.can_id == cur.can_id)) begin
            pend_next    = 1'b0;
            hit_idx_next = pend_idx;
            sig_i_next   = '0;
            sig_n_next   = slot_rdata.count;
            state_next   = (slot_rdata.count == 5'd0) ? ST_IDLE : ST_FETCH;
          end else if (pend_idx == SAW'(MSG_SLOTS - 1)) begin
            pend_next  = 1'b0;
            sig_i_next = '0;
            sig_n_next = {1'b0, cur.nb};
            state_next = (cur.nb == 4'd0) ? ST_IDLE : ST_RAW;
          end
        end
      end

      // Read the descriptor of the current signal.
      ST_FETCH: begin
        ent_re     = 1'b1;
        state_next = ST_EMIT;
      end

      // Hand the extracted signal to the output register.
      ST_EMIT: begin
        if (out_free) begin
          oload      = 1'b1;
          oitem_next = '{frame_id: cur.can_id, sig_start: ent_rdata.start,
                         sig_bits: ent_rdata.len, value: ent_value,
                         known: 1'b1, last: is_last};
          sig_i_next = sig_i + 5'd1;
          state_next = is_last ? ST_IDLE : ST_FETCH;
        end
      end

      // Unknown identifier: one raw byte per result.
      ST_RAW: begin
        if (out_free) begin
          oload      = 1'b1;
          oitem_next = '{frame_id: cur.can_id, sig_start: {sig_i[2:0], 3'b001},
                         sig_bits: 7'd8,
                         value: {56'd0, cur.data[8 * (7 - sig_i[2:0]) +: 8]},
                         known: 1'b0, last: is_last};
          sig_i_next = sig_i + 5'd1;
          if (is_last) begin
            state_next = ST_IDLE;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Output register valid.
    if (oload) begin
      ovalid_next = 1'b1;
    end else if (out_ready) begin
      ovalid_next = 1'b0;
    end else begin
      ovalid_next = ovalid;
    end
  end

  // The emit counter stays inside the frame's result count.
  `CSX_ASSERT(a_sig_in_range, !(state == ST_FETCH || state == ST_EMIT || state == ST_RAW) || (sig_i < sig_n))
  // A raw fallback never runs past eight bytes.
  `CSX_ASSERT(a_raw_bound, (state != ST_RAW) || (sig_n <= 5'd8))
  // The final result of a frame returns the sequencer to idle.
  `CSX_ASSERT_NEXT(a_last_idle, oload && oitem_next.last, state == ST_IDLE)
  // A descriptor read is always followed by its emit step.
  `CSX_ASSERT_NEXT(a_fetch_emit, state == ST_FETCH, state == ST_EMIT)

endmodule

// ===== rtl/can_signal_extractor_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_signal_extractor_core: table-driven CAN frame signal decoder
// Loads fill a message table and its signal descriptors; a decode finds the
// lowest matching slot and emits the extracted signals, or the raw bytes.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+-----------
//   in      | input     | in_valid / in_ready   | in_item_t
//   out     | output    | out_valid / out_ready | out_item_t
//
// A load is written to the table in the same cycle that it leaves the queue.
// A decode walks the table one slot a cycle, then fetches and emits each
// known signal in turn, or emits one raw byte per result.
// After reset a clearing pass invalidates every slot while in_ready is low.
// A two-entry queue lets the input side run ahead while results stall.
// ----------------------------------------------------------------------------
module can_signal_extractor_core
  import csx_pkg::*;
#(
  parameter int MSG_SLOTS    = MSG_SLOTS_DEF,
  parameter int SIGS_PER_MSG = SIGS_PER_MSG_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic   push_valid;
  logic   push_ready;
  qitem_t push_item;
  logic   q_valid;
  logic   q_ready;
  qitem_t q_item;
  logic   clearing;

  // Classification front end.
  csx_front #(
    .MSG_SLOTS    (MSG_SLOTS),
    .SIGS_PER_MSG (SIGS_PER_MSG)
  ) u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .clearing   (clearing),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Decoupling queue.
  csx_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_item  (push_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  // Table, search and emission back end.
  csx_back #(
    .MSG_SLOTS    (MSG_SLOTS),
    .SIGS_PER_MSG (SIGS_PER_MSG)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
